// ===== design/lhal_pkg.sv =====
// Package for the LED hit aging list: list depth, field widths and the
// one-hot sequencer states. It has no dependencies.
package lhal_pkg;

    localparam int HIT_DEPTH = 8;
    localparam int IDX_W     = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HIT_DEPTH + 1);

    localparam int COORD_W   = 8;
    localparam int SPEED_W   = 8;
    localparam int AGE_W     = 17;
    localparam int PROD_W    = AGE_W + SPEED_W;
    localparam int COUNT_W   = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [SPEED_W-1:0] SPEED_RESET    = 8'd128;
    localparam logic [PROD_W-1:0]  AGE_LIMIT_BASE = PROD_W'(65535);

    localparam logic CMD_HIT  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WORK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== design/led_hit_aging_list.sv =====
// LED hit aging list: top level with the entry store, the sequencer and the
// shared age update unit. Depends on lhal_pkg.

// A hit word appends one entry unless the list is full. On a tick word a
// single add, multiply and compare unit visits one stored entry per cycle,
// ages it, and either writes it back at the compacted position or counts
// it as expired if speed != 0 and (age + speed) * speed > 65535, the same
// test as age + speed > 65535 / speed. The block takes no new word while
// one is in work; it may accept the next word while the previous result
// still waits on the master side. The user must write speed through the
// cfg port only while the block is idle; the block does not enforce this.
module led_hit_aging_list (
    input  logic                          clk,
    input  logic                          rst_n,
    // cfg_data: speed[7:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lhal_pkg::SPEED_W-1:0]  cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // s_axis_tdata: led_x[7:0], led_y[15:8], led_number[23:16]
    input  logic [lhal_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: cmd[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // m_axis_tdata: entry_count[3:0], stored[4], expired[8:5], zeros[15:9]
    output logic [lhal_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lhal_pkg::*;

    state_t               state_reg, state_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic [CNT_W-1:0]     expired_reg, expired_next;
    logic                 stored_reg, stored_next;
    logic                 cmd_reg;
    logic [COORD_W-1:0]   in_x_reg, in_y_reg, in_led_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [COORD_W-1:0]   xs_reg   [HIT_DEPTH];
    logic [COORD_W-1:0]   ys_reg   [HIT_DEPTH];
    logic [COORD_W-1:0]   leds_reg [HIT_DEPTH];
    logic [AGE_W-1:0]     ages_reg [HIT_DEPTH];

    logic                 in_fire, out_load;
    logic [IDX_W-1:0]     rd_idx;
    logic [AGE_W-1:0]     age_sum;
    logic [PROD_W-1:0]    age_prod;
    logic                 drop;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [COORD_W-1:0]   wr_x, wr_y, wr_led;
    logic [AGE_W-1:0]     wr_age;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Shared aging unit: reads the entry under the read pointer.
    assign rd_idx   = rd_reg[IDX_W-1:0];
    assign age_sum  = ages_reg[rd_idx] + AGE_W'(speed_reg);
    assign age_prod = PROD_W'(age_sum) * PROD_W'(speed_reg);
    assign drop     = (speed_reg != '0) && (age_prod > AGE_LIMIT_BASE);

    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        rd_next      = rd_reg;
        keep_next    = keep_reg;
        expired_next = expired_reg;
        stored_next  = stored_reg;
        wr_en        = 1'b0;
        wr_idx       = held_reg[IDX_W-1:0];
        wr_x         = in_x_reg;
        wr_y         = in_y_reg;
        wr_led       = in_led_reg;
        wr_age       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next   = ST_WORK;
                    rd_next      = '0;
                    keep_next    = '0;
                    expired_next = '0;
                    stored_next  = 1'b0;
                end
            end
            ST_WORK:
            begin
                if (cmd_reg == CMD_HIT)
                begin
                    if (held_reg < CNT_W'(HIT_DEPTH))
                    begin
                        wr_en       = 1'b1;
                        held_next   = held_reg + 1'b1;
                        stored_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (rd_reg < held_reg)
                begin
                    rd_next = rd_reg + 1'b1;
                    if (drop)
                    begin
                        expired_next = expired_reg + 1'b1;
                    end
                    else
                    begin
                        // Kept entries slide down over the expired ones.
                        wr_en     = 1'b1;
                        wr_idx    = keep_reg[IDX_W-1:0];
                        wr_x      = xs_reg[rd_idx];
                        wr_y      = ys_reg[rd_idx];
                        wr_led    = leds_reg[rd_idx];
                        wr_age    = age_sum;
                        keep_next = keep_reg + 1'b1;
                    end
                end
                else
                begin
                    held_next  = keep_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            speed_reg     <= SPEED_RESET;
            held_reg      <= '0;
            rd_reg        <= '0;
            keep_reg      <= '0;
            expired_reg   <= '0;
            stored_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            rd_reg      <= rd_next;
            keep_reg    <= keep_next;
            expired_reg <= expired_next;
            stored_reg  <= stored_next;
            if (cfg_valid && cfg_ready)
            begin
                speed_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= s_axis_tuser;
            in_x_reg   <= s_axis_tdata[7:0];
            in_y_reg   <= s_axis_tdata[15:8];
            in_led_reg <= s_axis_tdata[23:16];
        end
        if (out_load)
        begin
            out_data_reg <= {7'b0, COUNT_W'(expired_reg), stored_reg, COUNT_W'(held_reg)};
        end
        if (wr_en)
        begin
            xs_reg[wr_idx]   <= wr_x;
            ys_reg[wr_idx]   <= wr_y;
            leds_reg[wr_idx] <= wr_led;
            ages_reg[wr_idx] <= wr_age;
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(HIT_DEPTH))
        else $error("entry count exceeds list depth");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORK) |-> (keep_reg <= rd_reg && rd_reg <= held_reg))
        else $error("compaction pointers out of order");

    a_tick_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORK && cmd_reg == CMD_TICK) |-> (keep_reg + expired_reg == rd_reg))
        else $error("kept plus expired does not match entries visited");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done state");

endmodule
